>>> rtl/battery_presence_detector_core_macros.svh
`ifndef BATTERY_PRESENCE_DETECTOR_CORE_MACROS_SVH
`define BATTERY_PRESENCE_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bpd_pkg.sv
package bpd_pkg;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;
    localparam int RUN_BITS  = 8;

    typedef logic [RUN_BITS-1:0] run_t;
    typedef logic [2:0]          reg_index_t;

    localparam reg_index_t REG_BAND_LOW    = 3'd0;
    localparam reg_index_t REG_BAND_HIGH   = 3'd1;
    localparam reg_index_t REG_MAX_STEP    = 3'd2;
    localparam reg_index_t REG_ABSENT_RUN  = 3'd3;
    localparam reg_index_t REG_PRESENT_RUN = 3'd4;

    localparam run_t RUN_MAX = 8'd255;

    localparam logic [31:0] BAND_LOW_RESET    = 32'd2310;
    localparam logic [31:0] BAND_HIGH_RESET   = 32'd4830;
    localparam logic [31:0] MAX_STEP_RESET    = 32'd250;
    localparam run_t        ABSENT_RUN_RESET  = 8'd6;
    localparam run_t        PRESENT_RUN_RESET = 8'd10;

    function automatic run_t run_inc(input run_t r);
        return (r == RUN_MAX) ? RUN_MAX : run_t'(r + 8'd1);
    endfunction

endpackage

>>> rtl/battery_presence_detector_core.sv
// Battery presence detector core.
// Input channel: in_valid / in_stall with sample_mv, one millivolt sample per
// transfer. Output channel: out_valid / out_stall with battery_present and
// gated_mv, exactly one result per accepted sample, in order.
// A transfer happens on a rising edge where valid is high and stall is low.
// The band, step and run-length registers sit on an APB port (word address
// paddr[4:2]); write them only while no sample is in flight.
// Each result is registered, in the result register or, while the receiver
// stalls, in the skid. Throughput: one sample per cycle while in_stall is low;
// the compare, absolute difference and run-counter update are combinational.
// A two-entry result buffer (result register plus skid) keeps the input open
// for one more transfer while the receiver stalls; in_stall rises only when
// both entries are full, and drops the cycle after a result is taken.
// Reset (rst_n low, asynchronous) empties the buffer, clears the run counters
// and the previous-sample mark, sets the present flag and loads the register
// defaults.
module battery_presence_detector_core
    import bpd_pkg::*;
#(
    parameter int SAMPLE_BITS = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_BITS-1:0]   paddr,
    input  logic [DATA_BITS-1:0]   pwdata,
    output logic [DATA_BITS-1:0]   prdata,
    output logic                   pready,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample_mv,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   battery_present,
    output logic [SAMPLE_BITS-1:0] gated_mv
);

    typedef logic [SAMPLE_BITS-1:0] mv_t;
    typedef logic [SAMPLE_BITS:0]   mv_diff_t;

    mv_t  band_low_reg;
    mv_t  band_high_reg;
    mv_t  max_step_reg;
    run_t absent_run_reg;
    run_t present_run_reg;

    logic seen_before_reg;
    mv_t  previous_mv_reg;
    run_t bad_run_reg;
    run_t good_run_reg;
    logic present_flag_reg;

    logic main_valid_reg;
    logic main_present_reg;
    mv_t  main_mv_reg;
    logic skid_valid_reg;
    logic skid_present_reg;
    mv_t  skid_mv_reg;

    logic       cfg_write;
    reg_index_t cfg_index;
    logic       push;
    logic       pop;
    logic       bad;
    mv_diff_t   diff_up;
    mv_diff_t   diff_down;
    mv_t        step_mv;
    run_t       bad_run_next;
    run_t       good_run_next;
    logic       present_flag_next;
    mv_t        result_mv;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_low_reg    <= BAND_LOW_RESET[SAMPLE_BITS-1:0];
            band_high_reg   <= BAND_HIGH_RESET[SAMPLE_BITS-1:0];
            max_step_reg    <= MAX_STEP_RESET[SAMPLE_BITS-1:0];
            absent_run_reg  <= ABSENT_RUN_RESET;
            present_run_reg <= PRESENT_RUN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BAND_LOW:    band_low_reg    <= pwdata[SAMPLE_BITS-1:0];
                REG_BAND_HIGH:   band_high_reg   <= pwdata[SAMPLE_BITS-1:0];
                REG_MAX_STEP:    max_step_reg    <= pwdata[SAMPLE_BITS-1:0];
                REG_ABSENT_RUN:  absent_run_reg  <= pwdata[RUN_BITS-1:0];
                REG_PRESENT_RUN: present_run_reg <= pwdata[RUN_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_BAND_LOW:    prdata = DATA_BITS'(band_low_reg);
            REG_BAND_HIGH:   prdata = DATA_BITS'(band_high_reg);
            REG_MAX_STEP:    prdata = DATA_BITS'(max_step_reg);
            REG_ABSENT_RUN:  prdata = DATA_BITS'(absent_run_reg);
            REG_PRESENT_RUN: prdata = DATA_BITS'(present_run_reg);
            default:         prdata = '0;
        endcase
    end

    assign in_stall  = skid_valid_reg;
    assign push      = in_valid && !in_stall;
    assign out_valid = main_valid_reg;
    assign pop       = main_valid_reg && !out_stall;

    assign diff_up   = {1'b0, sample_mv} - {1'b0, previous_mv_reg};
    assign diff_down = {1'b0, previous_mv_reg} - {1'b0, sample_mv};
    assign step_mv   = diff_up[SAMPLE_BITS] ? diff_down[SAMPLE_BITS-1:0]
                                            : diff_up[SAMPLE_BITS-1:0];

    always_comb
    begin
        bad = (sample_mv < band_low_reg) || (sample_mv > band_high_reg)
              || (seen_before_reg && (step_mv > max_step_reg));

        if (bad)
        begin
            bad_run_next  = run_inc(bad_run_reg);
            good_run_next = '0;
        end
        else
        begin
            bad_run_next  = '0;
            good_run_next = run_inc(good_run_reg);
        end

        present_flag_next = present_flag_reg;
        if (present_flag_reg && (bad_run_next >= absent_run_reg))
            present_flag_next = 1'b0;
        else if (!present_flag_reg && (good_run_next >= present_run_reg))
            present_flag_next = 1'b1;

        result_mv = present_flag_next ? sample_mv : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_before_reg  <= 1'b0;
            previous_mv_reg  <= '0;
            bad_run_reg      <= '0;
            good_run_reg     <= '0;
            present_flag_reg <= 1'b1;
        end
        else if (push)
        begin
            seen_before_reg  <= 1'b1;
            previous_mv_reg  <= sample_mv;
            bad_run_reg      <= bad_run_next;
            good_run_reg     <= good_run_next;
            present_flag_reg <= present_flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            // refill from skid first to keep order
            if (skid_valid_reg)
            begin
                main_present_reg <= skid_present_reg;
                main_mv_reg      <= skid_mv_reg;
            end
            else if (push)
            begin
                main_present_reg <= present_flag_next;
                main_mv_reg      <= result_mv;
            end
        end
        else if (push)
        begin
            skid_present_reg <= present_flag_next;
            skid_mv_reg      <= result_mv;
        end
    end

    assign battery_present = main_present_reg;
    assign gated_mv        = main_mv_reg;

endmodule

>>> rtl/bpd_checker.sv
`include "battery_presence_detector_core_macros.svh"

module bpd_checker #(
    parameter int SAMPLE_BITS = 14
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   battery_present,
    input logic [SAMPLE_BITS-1:0] gated_mv
);

    `BPD_ASSERT_NOW(a_absent_gated, clk, rst_n, out_valid && !battery_present,
        gated_mv == '0, "gated sample not zero while battery absent")

    `BPD_ASSERT_NOW(a_stall_needs_result, clk, rst_n, in_stall, out_valid,
        "input stalled with no result waiting")

    `BPD_ASSERT_NEXT(a_stall_only_on_backpressure, clk, rst_n, !in_stall,
        !in_stall || ($past(out_stall) && $past(in_valid)),
        "input stall rose without a stalled output and an input transfer")

    `BPD_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(battery_present) && $stable(gated_mv),
        "stalled result changed")

endmodule

bind battery_presence_detector_core bpd_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_bpd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .battery_present (battery_present),
    .gated_mv        (gated_mv)
);
